>>> design/hilb_pkg.sv
// Shared types, codes and curve tables for the Hilbert code converter.
package hilb_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned CODE_W  = 64;
    localparam int unsigned LVL_W   = 6;
    localparam int unsigned LIDX_W  = 5;
    localparam int unsigned ST_W    = 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_WALK,
        S_DONE
    } t_state;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    localparam logic [5:0] LEVELS_RESET = 6'd16;

    // Encode tables are indexed by {state, x bit, y bit}.
    localparam logic [1:0] ENC_DIGIT [16] = '{
        2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd3, 2'd1, 2'd2,
        2'd2, 2'd3, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0
    };
    localparam logic [1:0] ENC_STATE [16] = '{
        2'd1, 2'd0, 2'd3, 2'd0, 2'd0, 2'd2, 2'd1, 2'd1,
        2'd2, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3, 2'd0, 2'd2
    };
    // Decode tables are indexed by {state, code digit}; the pair is {x, y}.
    localparam logic [1:0] DEC_PAIR [16] = '{
        2'd0, 2'd1, 2'd3, 2'd2, 2'd0, 2'd2, 2'd3, 2'd1,
        2'd3, 2'd2, 2'd0, 2'd1, 2'd3, 2'd1, 2'd0, 2'd2
    };
    localparam logic [1:0] DEC_STATE [16] = '{
        2'd1, 2'd0, 2'd0, 2'd3, 2'd0, 2'd1, 2'd1, 2'd2,
        2'd3, 2'd2, 2'd2, 2'd1, 2'd2, 2'd3, 2'd3, 2'd0
    };

    // Position of the highest set bit, or -1 when the word is zero.
    function automatic logic signed [6:0] top_bit64(input logic [63:0] v);
        logic signed [6:0] r;
        r = -7'sd1;
        for (int b = 0; b < 64; b++) begin
            if (v[b]) begin
                r = 7'(b);
            end
        end
        return r;
    endfunction

endpackage

>>> design/incremental_hilbert_encode_decode.sv
// Top level of the incremental two-dimensional Hilbert code encoder and decoder.
//
// An item is taken in one transfer, then the per-level curve state for the
// first level to walk is read from a small state memory, the walk runs one
// curve level per cycle through the state tables while it writes the states
// that the next item will reuse back into that memory, and the result is then
// placed in the output register once that register is free or being read.
// The walk starts at the start level s (between -1 and levels - 1; at -1 no
// level is walked); the next input transfer is taken once the result sits in
// the output register.
// The state memory is cleared at reset and on a write of levels through
// per-entry valid bits, so no clearing pass is needed.
module incremental_hilbert_encode_decode #(
    parameter int unsigned MAX_LEVELS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hilb_pkg::LVL_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [hilb_pkg::COORD_W-1:0] i_point_x,
    input  logic [hilb_pkg::COORD_W-1:0] i_point_y,
    input  logic [hilb_pkg::COORD_W-1:0] i_next_x,
    input  logic [hilb_pkg::COORD_W-1:0] i_next_y,
    input  logic [hilb_pkg::CODE_W-1:0]  i_curve_code,
    input  logic [hilb_pkg::CODE_W-1:0]  i_next_code,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [hilb_pkg::CODE_W-1:0]  o_result_code,
    output logic [hilb_pkg::COORD_W-1:0] o_result_x,
    output logic [hilb_pkg::COORD_W-1:0] o_result_y
);

    import hilb_pkg::*;

    localparam int unsigned DEPTH = MAX_LEVELS + 1;
    localparam int unsigned AW    = $clog2(DEPTH);

    function automatic logic [LVL_W-1:0] eff_levels(input logic [LVL_W-1:0] lv);
        logic [LVL_W-1:0] k;
        k = lv;
        if (lv == '0) begin
            k = LVL_W'(1);
        end else if (lv > LVL_W'(MAX_LEVELS)) begin
            k = LVL_W'(MAX_LEVELS);
        end
        return k;
    endfunction

    t_state r_state, n_state;

    logic [LVL_W-1:0]        r_levels;
    logic signed [LVL_W-1:0] r_start_level;
    logic [DEPTH-1:0]        r_valid;
    logic                    r_rd_valid;

    t_op                     r_op;
    logic [COORD_W-1:0]      r_px, r_py, r_nx, r_ny;
    logic [CODE_W-1:0]       r_cc, r_nc;
    logic signed [LVL_W-1:0] r_s;
    logic signed [LVL_W-1:0] r_ns;
    logic [LIDX_W-1:0]       r_lvl;
    logic [ST_W-1:0]         r_st;
    logic [CODE_W-1:0]       r_acc_code;
    logic [COORD_W-1:0]      r_acc_x, r_acc_y;

    logic [CODE_W-1:0]       r_prev_code;
    logic [COORD_W-1:0]      r_prev_x, r_prev_y;

    logic                    r_out_valid;
    logic [CODE_W-1:0]       r_res_code;
    logic [COORD_W-1:0]      r_res_x, r_res_y;

    logic                    in_xfer;
    logic                    load_done;
    logic                    mem_we;
    logic [LVL_W-1:0]        k_eff;
    logic [LVL_W-1:0]        k_cfg;
    logic signed [LVL_W-1:0] s_clamp;
    logic [LVL_W-1:0]        rd_full;
    logic [LVL_W-1:0]        wr_full;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [ST_W-1:0]         ram_rdata;
    logic signed [6:0]       tb_enc, tb_dec;
    logic signed [LVL_W-1:0] ns_calc;
    logic [3:0]              idx;
    logic [1:0]              digit;
    logic [1:0]              pair;
    logic [ST_W-1:0]         nst;
    logic [LVL_W-1:0]        s_plus1;
    logic [CODE_W-1:0]       code_mask;
    logic [COORD_W-1:0]      coord_mask;

    // Effective level count, clamped start level and memory addresses.
    always_comb begin
        k_eff   = eff_levels(r_levels);
        k_cfg   = eff_levels(i_cfg_wdata);
        s_clamp = r_start_level;
        if (r_start_level > $signed(k_eff - LVL_W'(1))) begin
            s_clamp = $signed(k_eff - LVL_W'(1));
        end
        rd_full = k_eff - $unsigned(s_clamp) - LVL_W'(1);
        rd_addr = rd_full[AW-1:0];
        wr_full = k_eff - {1'b0, r_lvl};
        wr_addr = wr_full[AW-1:0];
    end

    // Start level of the next item.
    always_comb begin
        if (r_nx == r_px) begin
            tb_enc = top_bit64({32'd0, r_ny ^ r_py});
        end else begin
            tb_enc = top_bit64({32'd0, r_nx ^ r_px});
        end
        tb_dec = top_bit64(r_cc ^ r_nc);
        if (r_op == OP_ENCODE) begin
            ns_calc = tb_enc[LVL_W-1:0];
        end else if (tb_dec[6]) begin
            ns_calc = '0;
        end else begin
            ns_calc = $signed({1'b0, tb_dec[LVL_W-1:1]});
        end
    end

    // One curve level through the state tables.
    always_comb begin
        if (r_op == OP_ENCODE) begin
            idx = {r_st, r_px[r_lvl], r_py[r_lvl]};
            nst = ENC_STATE[idx];
        end else begin
            idx = {r_st, r_cc[{r_lvl, 1'b0} +: 2]};
            nst = DEC_STATE[idx];
        end
        digit = ENC_DIGIT[idx];
        pair  = DEC_PAIR[idx];
    end

    // Masks that keep the previous result above the walked levels.
    always_comb begin
        s_plus1    = $unsigned(r_s) + LVL_W'(1);
        code_mask  = ~(CODE_W'(0)) << {s_plus1, 1'b0};
        coord_mask = ~(COORD_W'(0)) << s_plus1;
    end

    hilb_ram #(
        .WIDTH (ST_W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (wr_addr),
        .i_wdata (nst),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_state = r_s[LVL_W-1] ? S_DONE : S_WALK;
            end
            S_WALK: begin
                if (r_lvl == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (load_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        in_xfer    = i_in_valid && o_in_ready;
        load_done  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
        mem_we     = (r_state == S_WALK) && ($signed({1'b0, r_lvl}) > r_ns);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_levels      <= LEVELS_RESET;
            r_start_level <= $signed(LEVELS_RESET - LVL_W'(1));
            r_valid       <= '0;
            r_prev_code   <= '0;
            r_prev_x      <= '0;
            r_prev_y      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mem_we) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (load_done) begin
                r_start_level <= r_ns;
                r_out_valid   <= 1'b1;
                if (r_op == OP_ENCODE) begin
                    r_prev_code <= r_acc_code | (r_prev_code & code_mask);
                end else begin
                    r_prev_x <= r_acc_x | (r_prev_x & coord_mask);
                    r_prev_y <= r_acc_y | (r_prev_y & coord_mask);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_levels      <= i_cfg_wdata;
                r_start_level <= $signed(k_cfg - LVL_W'(1));
                r_valid       <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op       <= t_op'(i_operation);
            r_px       <= i_point_x;
            r_py       <= i_point_y;
            r_nx       <= i_next_x;
            r_ny       <= i_next_y;
            r_cc       <= i_curve_code;
            r_nc       <= i_next_code;
            r_s        <= s_clamp;
            r_lvl      <= s_clamp[LIDX_W-1:0];
            r_rd_valid <= r_valid[rd_addr];
            r_acc_code <= '0;
            r_acc_x    <= '0;
            r_acc_y    <= '0;
        end
        if (r_state == S_LOAD) begin
            r_st <= r_rd_valid ? ram_rdata : '0;
            r_ns <= ns_calc;
        end
        if (r_state == S_WALK) begin
            r_st       <= nst;
            r_lvl      <= r_lvl - LIDX_W'(1);
            r_acc_code <= {r_acc_code[CODE_W-3:0], digit};
            r_acc_x    <= {r_acc_x[COORD_W-2:0], pair[1]};
            r_acc_y    <= {r_acc_y[COORD_W-2:0], pair[0]};
        end
        if (load_done) begin
            if (r_op == OP_ENCODE) begin
                r_res_code <= r_acc_code | (r_prev_code & code_mask);
                r_res_x    <= '0;
                r_res_y    <= '0;
            end else begin
                r_res_code <= '0;
                r_res_x    <= r_acc_x | (r_prev_x & coord_mask);
                r_res_y    <= r_acc_y | (r_prev_y & coord_mask);
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_code = r_res_code;
    assign o_result_x    = r_res_x;
    assign o_result_y    = r_res_y;

    a_cfg_clears_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_valid == '0))
        else $error("state memory not cleared by a levels write");

    a_cfg_start_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_start_level == $signed(k_eff - LVL_W'(1))))
        else $error("start level not reset by a levels write");

    a_no_write_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !mem_we)
        else $error("state memory written while an input transfer may be taken");

    a_done_presents_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_done |=> (o_out_valid && o_in_ready))
        else $error("finished item did not reach the output register");

endmodule

>>> design/hilb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module hilb_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
